// ===== hw/rtl/lrdu_pkg.sv =====
// Shared types, constants and microcode program of the Lehmer random draw unit.
package lrdu_pkg;

   localparam logic [30:0] LCG_MOD    = 31'h7fff_ffff;
   localparam logic [14:0] LCG_MULT   = 15'd16807;
   localparam logic [31:0] SEED_RESET = 32'd12345;
   localparam logic [30:0] SKEW_MAX   = 31'd30;
   localparam int          DIV_STEPS  = 31;
   localparam int          CNT_W      = $clog2(DIV_STEPS);
   localparam int          PC_W       = 3;

   typedef enum logic [1:0] {
      REQ_NEXT    = 2'd0,
      REQ_UNIFORM = 2'd1,
      REQ_ONE_IN  = 2'd2,
      REQ_SKEWED  = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_MUL,
      OP_FOLD,
      OP_DIV,
      OP_KEEP,
      OP_RESP
   } op_type;

   typedef enum logic [2:0] {
      COND_NONE,
      COND_REQ,
      COND_BAD,
      COND_NEXT,
      COND_DIV_LAST,
      COND_NOT_SKEW,
      COND_RSP_FREE
   } cond_type;

   localparam logic [PC_W-1:0] STEP_IDLE  = 3'd0;
   localparam logic [PC_W-1:0] STEP_MUL1  = 3'd1;
   localparam logic [PC_W-1:0] STEP_FOLD1 = 3'd2;
   localparam logic [PC_W-1:0] STEP_DIV   = 3'd3;
   localparam logic [PC_W-1:0] STEP_KEEP  = 3'd4;
   localparam logic [PC_W-1:0] STEP_MUL2  = 3'd5;
   localparam logic [PC_W-1:0] STEP_FOLD2 = 3'd6;
   localparam logic [PC_W-1:0] STEP_RESP  = 3'd7;

   // hold: stay on this step while the condition is false
   typedef struct packed {
      op_type          op;
      cond_type        cond;
      logic            hold;
      logic [PC_W-1:0] target;
   } ucode_type;

   typedef struct packed {
      logic bad;
      logic is_next;
      logic is_skew;
      logic div_last;
   } status_type;

   typedef struct packed {
      op_type op;
      logic   go;
   } ctrl_type;

   function automatic ucode_type ucode_rom(input logic [PC_W-1:0] pc);
      ucode_type w;
      w = '{op: OP_IDLE, cond: COND_NONE, hold: 1'b0, target: STEP_IDLE};
      unique case (pc)
         STEP_IDLE:  w = '{op: OP_IDLE, cond: COND_REQ,      hold: 1'b1, target: STEP_MUL1};
         STEP_MUL1:  w = '{op: OP_MUL,  cond: COND_BAD,      hold: 1'b0, target: STEP_RESP};
         STEP_FOLD1: w = '{op: OP_FOLD, cond: COND_NEXT,     hold: 1'b0, target: STEP_RESP};
         STEP_DIV:   w = '{op: OP_DIV,  cond: COND_DIV_LAST, hold: 1'b1, target: STEP_KEEP};
         STEP_KEEP:  w = '{op: OP_KEEP, cond: COND_NOT_SKEW, hold: 1'b0, target: STEP_RESP};
         STEP_MUL2:  w = '{op: OP_MUL,  cond: COND_NONE,     hold: 1'b0, target: STEP_IDLE};
         STEP_FOLD2: w = '{op: OP_FOLD, cond: COND_NONE,     hold: 1'b0, target: STEP_IDLE};
         STEP_RESP:  w = '{op: OP_RESP, cond: COND_RSP_FREE, hold: 1'b1, target: STEP_IDLE};
         default:    w = '{op: OP_IDLE, cond: COND_NONE,     hold: 1'b0, target: STEP_IDLE};
      endcase
      return w;
   endfunction

endpackage

// ===== hw/rtl/lrdu_req_if.sv =====
// Request channel interface of the Lehmer random draw unit.
interface lrdu_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [30:0] n;

   modport source(output valid, req_type, n, input ready);
   modport sink(input valid, req_type, n, output ready);
endinterface

// ===== hw/rtl/lrdu_rsp_if.sv =====
// Response channel interface of the Lehmer random draw unit.
interface lrdu_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] value;
   logic        hit;
   logic        bad_n;

   modport source(output valid, value, hit, bad_n, input ready);
   modport sink(input valid, value, hit, bad_n, output ready);
endinterface

// ===== hw/rtl/lrdu_sequencer.sv =====
// Microcode sequencer: step counter, program table lookup and jump logic.
module lrdu_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_free,
   input  lrdu_pkg::status_type status,
   output lrdu_pkg::ctrl_type   ctrl
);

   logic [lrdu_pkg::PC_W-1:0] pc_ff;
   logic [lrdu_pkg::PC_W-1:0] pc_in;
   lrdu_pkg::ucode_type       word;
   logic                      cond_true;

   assign word = lrdu_pkg::ucode_rom(pc_ff);

   always_comb begin
      unique case (word.cond)
         lrdu_pkg::COND_NONE:     cond_true = 1'b0;
         lrdu_pkg::COND_REQ:      cond_true = req_valid;
         lrdu_pkg::COND_BAD:      cond_true = status.bad;
         lrdu_pkg::COND_NEXT:     cond_true = status.is_next;
         lrdu_pkg::COND_DIV_LAST: cond_true = status.div_last;
         lrdu_pkg::COND_NOT_SKEW: cond_true = !status.is_skew;
         lrdu_pkg::COND_RSP_FREE: cond_true = rsp_free;
         default:                 cond_true = 1'b0;
      endcase
   end

   always_comb begin
      if (cond_true) begin
         pc_in = word.target;
      end else if (word.hold) begin
         pc_in = pc_ff;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   assign ctrl.op = word.op;
   assign ctrl.go = cond_true;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= lrdu_pkg::STEP_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

// ===== hw/rtl/lrdu_datapath.sv =====
// Datapath: generator state, multiply and Mersenne fold, restoring divider, result.
module lrdu_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  lrdu_pkg::ctrl_type   ctrl,
   input  logic [1:0]           req_type,
   input  logic [30:0]          req_n,
   input  logic                 csr_we,
   input  logic [31:0]          csr_wdata,
   output lrdu_pkg::status_type status,
   output logic [30:0]          rsp_value,
   output logic                 rsp_hit,
   output logic                 rsp_bad_n
);

   logic [30:0]                state_ff;
   logic [45:0]                prod_ff;
   logic [1:0]                 type_ff;
   logic [30:0]                n_ff;
   logic [30:0]                quo_ff;
   logic [30:0]                rem_ff;
   logic [30:0]                div_ff;
   logic [lrdu_pkg::CNT_W-1:0] cnt_ff;
   logic [4:0]                 k_ff;
   logic [30:0]                value_ff;
   logic                       hit_ff;
   logic                       bad_ff;

   logic [30:0] seed_state;
   logic [31:0] fold_sum;
   logic [30:0] fold_val;
   logic [30:0] div_sel;
   logic [31:0] trial;
   logic [31:0] trial_sub;
   logic [30:0] rem_next;
   logic [30:0] value_in;
   logic        is_bad;
   logic        uses_n;

   assign seed_state = ((csr_wdata[30:0] == '0) || (csr_wdata[30:0] == lrdu_pkg::LCG_MOD))
                       ? 31'd1 : csr_wdata[30:0];

   assign fold_sum = {17'd0, prod_ff[45:31]} + {1'b0, prod_ff[30:0]};
   assign fold_val = (fold_sum >= {1'b0, lrdu_pkg::LCG_MOD})
                     ? 31'(fold_sum - {1'b0, lrdu_pkg::LCG_MOD}) : fold_sum[30:0];

   // skewed divisor is min(n, 30) + 1
   assign div_sel = (type_ff != lrdu_pkg::REQ_SKEWED) ? n_ff
                  : (n_ff > lrdu_pkg::SKEW_MAX) ? (lrdu_pkg::SKEW_MAX + 31'd1)
                  : (n_ff + 31'd1);

   assign trial     = {rem_ff, quo_ff[30]};
   assign trial_sub = trial - {1'b0, div_ff};
   assign rem_next  = (trial >= {1'b0, div_ff}) ? trial_sub[30:0] : trial[30:0];

   assign uses_n = (type_ff == lrdu_pkg::REQ_UNIFORM) || (type_ff == lrdu_pkg::REQ_ONE_IN);
   assign is_bad = uses_n && (n_ff == '0);

   always_comb begin
      value_in = '0;
      if (!is_bad) begin
         case (type_ff)
            lrdu_pkg::REQ_NEXT:    value_in = state_ff;
            lrdu_pkg::REQ_UNIFORM: value_in = rem_ff;
            lrdu_pkg::REQ_SKEWED:  value_in = state_ff & ~(lrdu_pkg::LCG_MOD << k_ff);
            default:               value_in = '0;
         endcase
      end
   end

   assign status.bad      = is_bad;
   assign status.is_next  = (type_ff == lrdu_pkg::REQ_NEXT);
   assign status.is_skew  = (type_ff == lrdu_pkg::REQ_SKEWED);
   assign status.div_last = (cnt_ff == lrdu_pkg::CNT_W'(lrdu_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrdu_pkg::SEED_RESET[30:0];
      end else if (csr_we) begin
         state_ff <= seed_state;
      end else if (ctrl.op == lrdu_pkg::OP_FOLD) begin
         state_ff <= fold_val;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.op == lrdu_pkg::OP_IDLE && ctrl.go) begin
         type_ff <= req_type;
         n_ff    <= req_n;
      end
      if (ctrl.op == lrdu_pkg::OP_MUL) begin
         prod_ff <= {15'd0, state_ff} * {31'd0, lrdu_pkg::LCG_MULT};
      end
      if (ctrl.op == lrdu_pkg::OP_FOLD) begin
         quo_ff <= fold_val;
         rem_ff <= '0;
         div_ff <= div_sel;
         cnt_ff <= '0;
      end else if (ctrl.op == lrdu_pkg::OP_DIV) begin
         quo_ff <= {quo_ff[29:0], 1'b0};
         rem_ff <= rem_next;
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (ctrl.op == lrdu_pkg::OP_KEEP) begin
         k_ff <= rem_ff[4:0];
      end
      if (ctrl.op == lrdu_pkg::OP_RESP && ctrl.go) begin
         value_ff <= value_in;
         hit_ff   <= (type_ff == lrdu_pkg::REQ_ONE_IN) && !is_bad && (rem_ff == '0);
         bad_ff   <= is_bad;
      end
   end

   assign rsp_value = value_ff;
   assign rsp_hit   = hit_ff;
   assign rsp_bad_n = bad_ff;

endmodule

// ===== hw/rtl/lehmer_random_draw_unit.sv =====
// Lehmer random draw unit: minimal standard generator with modulo reductions.
// The sequencer multiplies, folds, then runs the 31-step restoring divider for
// uniform/one_in/skewed draws, and multiplies and folds again for skewed draws.
// The next request can be accepted as soon as the response is registered valid.
// Reset is synchronous: generator state 12345, sequencer idle, no response pending.
// A seed write reloads the state at once.
module lehmer_random_draw_unit (
   input  logic         clock,
   input  logic         reset,
   lrdu_req_if.sink     req,
   lrdu_rsp_if.source   rsp,
   input  logic         csr_we,
   input  logic [31:0]  csr_wdata
);

   lrdu_pkg::ctrl_type   ctrl;
   lrdu_pkg::status_type status;
   logic                 rsp_valid_ff;
   logic                 rsp_free;

   assign rsp_free  = !rsp_valid_ff || rsp.ready;
   assign req.ready = (ctrl.op == lrdu_pkg::OP_IDLE);
   assign rsp.valid = rsp_valid_ff;

   lrdu_sequencer u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .rsp_free  (rsp_free),
      .status    (status),
      .ctrl      (ctrl)
   );

   lrdu_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .req_type  (req.req_type),
      .req_n     (req.n),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_value (rsp.value),
      .rsp_hit   (rsp.hit),
      .rsp_bad_n (rsp.bad_n)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.op == lrdu_pkg::OP_RESP && ctrl.go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

`ifndef ASSERT_OFF
   a_bad_clean: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.bad_n |-> (rsp.value == '0) && !rsp.hit)
      else $error("bad_n response carries nonzero value or hit");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> !req.ready)
      else $error("request accepted while a request is in progress");

   a_rsp_from_resp_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(ctrl.op == lrdu_pkg::OP_RESP))
      else $error("response raised outside the response step");
`endif

endmodule

// ===== bench/lrdu_draw_checker.sv =====
// Checker of the Lehmer random draw unit: predicts each response and compares it.
module lrdu_draw_checker (
   input  logic        clock,
   input  logic        reset,
   lrdu_req_if         req,
   lrdu_rsp_if         rsp,
   input  logic        csr_we,
   input  logic [31:0] csr_wdata,
   output int          fail_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [30:0] value;
      logic        hit;
      logic        bad_n;
   } draw_outcome_type;

   logic [30:0]      lehmer_state;
   draw_outcome_type draw_queue[$];

   function automatic logic [30:0] seed_load_value(input logic [31:0] s);
      logic [30:0] v;
      v = s[30:0];
      if (v == '0 || v == lrdu_pkg::LCG_MOD) v = 31'd1;
      return v;
   endfunction

   // full 46-bit product, folded once with the Mersenne identity
   function automatic logic [30:0] park_miller_advance(input logic [30:0] s);
      logic [45:0] prod;
      logic [31:0] folded;
      prod   = 46'(s) * 46'(lrdu_pkg::LCG_MULT);
      folded = 32'(prod[30:0]) + 32'(prod[45:31]);
      if (folded >= 32'(lrdu_pkg::LCG_MOD)) folded = folded - 32'(lrdu_pkg::LCG_MOD);
      return folded[30:0];
   endfunction

   function automatic draw_outcome_type predict_draw(input lrdu_pkg::req_kind_type kind,
                                                     input logic [30:0] n);
      draw_outcome_type r;
      logic [30:0]      draw;
      logic [30:0]      clamp;
      logic [30:0]      width;
      r = '0;
      case (kind) inside
         lrdu_pkg::REQ_NEXT: begin
            lehmer_state = park_miller_advance(lehmer_state);
            r.value = lehmer_state;
         end
         lrdu_pkg::REQ_UNIFORM, lrdu_pkg::REQ_ONE_IN: begin
            if (n == '0) begin
               r.bad_n = 1'b1;
            end else begin
               lehmer_state = park_miller_advance(lehmer_state);
               draw = lehmer_state % n;
               if (kind == lrdu_pkg::REQ_UNIFORM) r.value = draw;
               else r.hit = (draw == '0);
            end
         end
         default: begin
            clamp = (n > lrdu_pkg::SKEW_MAX) ? lrdu_pkg::SKEW_MAX : n;
            lehmer_state = park_miller_advance(lehmer_state);
            width = lehmer_state % (clamp + 31'd1);
            lehmer_state = park_miller_advance(lehmer_state);
            r.value = lehmer_state & ((31'd1 << width) - 31'd1);
         end
      endcase
      return r;
   endfunction

   function automatic void flag_error(input string what);
      fail_count++;
      if (fail_count <= 10) $display("%0t ns draw check: %s", $time, what);
   endfunction

   always @(posedge clock) begin
      draw_outcome_type want;
      draw_outcome_type got;
      if (reset) begin
         lehmer_state = seed_load_value(lrdu_pkg::SEED_RESET);
         draw_queue.delete();
      end else begin
         if (csr_we) lehmer_state = seed_load_value(csr_wdata);
         if (rsp.valid && rsp.ready) begin
            got = '{value: rsp.value, hit: rsp.hit, bad_n: rsp.bad_n};
            if (draw_queue.size() == 0) begin
               flag_error($sformatf("unexpected item value=%h hit=%b bad_n=%b",
                                    got.value, got.hit, got.bad_n));
            end else begin
               want = draw_queue.pop_front();
               if (got.value !== want.value || got.hit !== want.hit
                   || got.bad_n !== want.bad_n)
                  flag_error($sformatf(
                     "expected value=%h hit=%b bad_n=%b, got value=%h hit=%b bad_n=%b",
                     want.value, want.hit, want.bad_n, got.value, got.hit, got.bad_n));
            end
         end
         if (req.valid && req.ready)
            draw_queue.push_back(predict_draw(lrdu_pkg::req_kind_type'(req.req_type),
                                              req.n));
      end
      pending_count = draw_queue.size();
   end

endmodule

// ===== bench/lehmer_random_draw_unit_test.sv =====
// Top of the Lehmer random draw unit testbench: clock, reset, stimulus and verdict.
module lehmer_random_draw_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_we;
   logic [31:0] csr_wdata;
   int          fail_count;
   int          pending_count;

   int          burst_left = 0;
   int          stall_run = 0;
   int          stall_style = 0;
   int          style_left = 0;
   int          kind_count[4] = '{0, 0, 0, 0};
   int          seed_loads = 0;

   lrdu_req_if req_link();
   lrdu_rsp_if rsp_link();

   lehmer_random_draw_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_link),
      .rsp       (rsp_link),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   lrdu_draw_checker draw_check (
      .clock         (clock),
      .reset         (reset),
      .req           (req_link),
      .rsp           (rsp_link),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // receiver: phases of always ready, coin flips, or long stalls
   always @(negedge clock) begin
      if (stall_run > 0) begin
         stall_run--;
         rsp_link.ready <= 1'b0;
      end else begin
         if (style_left == 0) begin
            stall_style = $urandom_range(0, 2);
            style_left  = $urandom_range(20, 200);
         end else begin
            style_left--;
         end
         case (stall_style)
            0: rsp_link.ready <= 1'b1;
            1: rsp_link.ready <= 1'($urandom_range(0, 1));
            default: begin
               if ($urandom_range(0, 3) == 0) begin
                  stall_run = $urandom_range(1, 50);
                  rsp_link.ready <= 1'b0;
               end else begin
                  rsp_link.ready <= 1'b1;
               end
            end
         endcase
      end
   end

   // called at a falling edge, returns at the falling edge after the item is taken
   task automatic send_draw(input lrdu_pkg::req_kind_type kind, input logic [30:0] n);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 2);
         if (gap > 0) begin
            req_link.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      req_link.valid    <= 1'b1;
      req_link.req_type <= kind;
      req_link.n        <= n;
      @(posedge clock);
      while (!req_link.ready) @(posedge clock);
      @(negedge clock);
      burst_left--;
      kind_count[kind]++;
   endtask

   task automatic settle();
      req_link.valid <= 1'b0;
      burst_left = 0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic load_seed(input logic [31:0] seed_value);
      settle();
      csr_we    <= 1'b1;
      csr_wdata <= seed_value;
      @(negedge clock);
      csr_we    <= 1'b0;
      seed_loads++;
   endtask

   function automatic logic [30:0] pick_n(input lrdu_pkg::req_kind_type kind);
      int unsigned roll;
      int unsigned shift;
      roll  = $urandom_range(0, 99);
      shift = $urandom_range(0, 30);
      if (kind == lrdu_pkg::REQ_SKEWED) begin
         if (roll < 80) return 31'($urandom_range(0, 32));
         return 31'($urandom);
      end
      if (roll < 4) return '0;
      if (roll < 40) return 31'($urandom_range(1, 64));
      if (roll < 55) return (31'd1 << shift) - 31'($urandom_range(0, 1));
      if (roll < 60) return lrdu_pkg::LCG_MOD;
      return 31'($urandom);
   endfunction

   initial begin
      logic [31:0]            seed_value;
      lrdu_pkg::req_kind_type kind;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_wdata         = '0;
      req_link.valid    = 1'b0;
      req_link.req_type = lrdu_pkg::REQ_NEXT;
      req_link.n        = '0;
      rsp_link.ready    = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // reset seed, zero modulus, modulus extremes, skew clamp
      send_draw(lrdu_pkg::REQ_NEXT, 31'd0);
      send_draw(lrdu_pkg::REQ_NEXT, lrdu_pkg::LCG_MOD);
      send_draw(lrdu_pkg::REQ_UNIFORM, 31'd0);
      send_draw(lrdu_pkg::REQ_ONE_IN, 31'd0);
      send_draw(lrdu_pkg::REQ_UNIFORM, 31'd1);
      send_draw(lrdu_pkg::REQ_UNIFORM, lrdu_pkg::LCG_MOD);
      send_draw(lrdu_pkg::REQ_UNIFORM, 31'h4000_0000);
      send_draw(lrdu_pkg::REQ_ONE_IN, 31'd1);
      send_draw(lrdu_pkg::REQ_ONE_IN, lrdu_pkg::LCG_MOD);
      send_draw(lrdu_pkg::REQ_ONE_IN, 31'd2);
      send_draw(lrdu_pkg::REQ_SKEWED, 31'd0);
      send_draw(lrdu_pkg::REQ_SKEWED, 31'd1);
      send_draw(lrdu_pkg::REQ_SKEWED, lrdu_pkg::SKEW_MAX);
      send_draw(lrdu_pkg::REQ_SKEWED, 31'd31);
      send_draw(lrdu_pkg::REQ_SKEWED, lrdu_pkg::LCG_MOD);
      send_draw(lrdu_pkg::REQ_UNIFORM, 31'd3);

      // seeds that fold to 1, the largest state, and a set top bit
      load_seed(32'h0000_0000);
      send_draw(lrdu_pkg::REQ_NEXT, 31'd0);
      load_seed(32'h7fff_ffff);
      send_draw(lrdu_pkg::REQ_NEXT, 31'd0);
      load_seed(32'hffff_ffff);
      send_draw(lrdu_pkg::REQ_NEXT, 31'd0);
      load_seed(32'h7fff_fffe);
      send_draw(lrdu_pkg::REQ_NEXT, 31'd0);
      send_draw(lrdu_pkg::REQ_UNIFORM, lrdu_pkg::LCG_MOD);
      load_seed(32'h8000_0001);
      send_draw(lrdu_pkg::REQ_SKEWED, lrdu_pkg::SKEW_MAX);

      for (int phase = 0; phase < 6; phase++) begin
         case ($urandom_range(0, 5))
            0: seed_value = 32'h0000_0000;
            1: seed_value = 32'hffff_ffff;
            2: seed_value = 32'h7fff_fffe;
            default: seed_value = $urandom;
         endcase
         load_seed(seed_value);
         repeat (300) begin
            kind = lrdu_pkg::req_kind_type'($urandom_range(0, 3));
            send_draw(kind, pick_n(kind));
            if ($urandom_range(0, 149) == 0) settle();
         end
      end

      settle();
      repeat (40) @(negedge clock);
      $display("Covered %0d next, %0d uniform, %0d one_in and %0d skewed requests",
               kind_count[lrdu_pkg::REQ_NEXT], kind_count[lrdu_pkg::REQ_UNIFORM],
               kind_count[lrdu_pkg::REQ_ONE_IN], kind_count[lrdu_pkg::REQ_SKEWED]);
      $display("under %0d seed loads, with random sender gaps and receiver stalls",
               seed_loads);
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
